// File: design/dense_matrix_multiply_defines.svh
// Assertion macros for the dense matrix multiply block.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef DENSE_MATRIX_MULTIPLY_DEFINES_SVH
`define DENSE_MATRIX_MULTIPLY_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DMM_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("dmm: assertion failed");

// Next-cycle implication, disabled during reset.
`define DMM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("dmm: assertion failed");

`endif

// File: design/dmm_pkg.sv
// Shared constants, types and helpers for the dense matrix multiply block.
// No dependencies; imported by dense_matrix_multiply and the bench.
package dmm_pkg;

    localparam int MAX_DIM  = 8;
    localparam int IDX_W    = $clog2(MAX_DIM);
    localparam int ADDR_W   = 2 * IDX_W;
    localparam int DEPTH    = MAX_DIM * MAX_DIM;
    localparam int DIM_W    = 4;
    localparam int VALUE_W  = 32;
    localparam int SUM_W    = 64;
    localparam int MODE_W   = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [MODE_W-1:0] MODE_LOAD_A  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_B  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_M  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_N = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_P  = 2'd2;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // Control tag that travels alongside one multiply-accumulate term.
    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last_term;
        logic             last_elem;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } tag_t;

    // Effective dimension: 0 acts as 1, anything above MAX_DIM as MAX_DIM.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        r = d;
        if (d == '0) r = DIM_W'(1);
        else if (d > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
        return r;
    endfunction

endpackage

// File: design/dmm_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module dmm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                       aclk,
    input  logic                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]           rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// File: design/dense_matrix_multiply.sv
// Dense fixed-point matrix multiply C = A x B with on-chip A and B stores.
// Depends on dmm_pkg, dmm_ram and dense_matrix_multiply_defines.svh.
//
// Load items (mode 0 for A, mode 1 for B) write one Q16.16 element each and may
// arrive back to back; loads outside the configured dimensions are
// dropped. A compute item (mode 2) walks C in row-major order and emits
// rows_m x cols_p Q32.32 results, last marked. Each result takes inner_n terms,
// one per cycle, through the A/B RAM read, a registered 32x32 multiply and a
// saturating 64-bit accumulate; the next element starts when the pipe is empty
// and the output register free, so a stalled result channel adds its stall time.
// No new item is taken until the last element of a compute has been produced.
// Entries must be loaded before a compute reads them.
`include "dense_matrix_multiply_defines.svh"

module dense_matrix_multiply
    import dmm_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,

    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [DIM_W-1:0]           cfg_data,

    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [MODE_W-1:0]          s_mode,
    input  logic [IDX_W-1:0]           s_row,
    input  logic [IDX_W-1:0]           s_col,
    input  logic signed [VALUE_W-1:0]  s_value,

    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [IDX_W-1:0]           m_out_row,
    output logic [IDX_W-1:0]           m_out_col,
    output logic signed [SUM_W-1:0]    m_sum,
    output logic                       m_last
);
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    // configuration
    logic [DIM_W-1:0] rows_m_reg, inner_n_reg, cols_p_reg;
    logic [DIM_W-1:0] dm, dn, dp;
    logic [IDX_W-1:0] dm_last, dn_last, dp_last;

    // sequencer
    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] i_reg, i_next, k_reg, k_next, j_reg, j_next;
    logic             done_reg, done_next;

    // pipeline
    tag_t                     tag0, tag1_reg, tag2_reg;
    logic [VALUE_W-1:0]       a_rdata, b_rdata;
    logic signed [SUM_W-1:0]  prod_reg, prod_next;
    logic signed [SUM_W-1:0]  acc_reg, acc_base, acc_next;
    logic signed [SUM_W:0]    acc_wide;

    // output register
    logic                     m_valid_reg;
    logic [IDX_W-1:0]         out_row_reg, out_col_reg;
    logic signed [SUM_W-1:0]  out_sum_reg;
    logic                     out_last_reg;

    logic                     s_xfer, load_a, load_b, start;
    logic                     out_free, pipe_empty;

    assign dm = clamp_dim(rows_m_reg);
    assign dn = clamp_dim(inner_n_reg);
    assign dp = clamp_dim(cols_p_reg);
    assign dm_last = dm[IDX_W-1:0] - IDX_W'(1);
    assign dn_last = dn[IDX_W-1:0] - IDX_W'(1);
    assign dp_last = dp[IDX_W-1:0] - IDX_W'(1);

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_m_reg  <= DIM_W'(1);
            inner_n_reg <= DIM_W'(1);
            cols_p_reg  <= DIM_W'(1);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_ROWS_M:  rows_m_reg  <= cfg_data;
                CFG_INNER_N: inner_n_reg <= cfg_data;
                CFG_COLS_P:  cols_p_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign s_xfer  = s_valid && s_ready;
    assign load_a  = s_xfer && (s_mode == MODE_LOAD_A)
                     && ({1'b0, s_row} < dm) && ({1'b0, s_col} < dn);
    assign load_b  = s_xfer && (s_mode == MODE_LOAD_B)
                     && ({1'b0, s_row} < dn) && ({1'b0, s_col} < dp);
    assign start   = s_xfer && (s_mode == MODE_COMPUTE);

    dmm_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_left_ram (
        .aclk  (aclk),
        .we    (load_a),
        .waddr ({s_row, s_col}),
        .wdata (s_value),
        .raddr ({i_reg, j_reg}),
        .rdata (a_rdata)
    );

    dmm_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_right_ram (
        .aclk  (aclk),
        .we    (load_b),
        .waddr ({s_row, s_col}),
        .wdata (s_value),
        .raddr ({j_reg, k_reg}),
        .rdata (b_rdata)
    );

    // next element may start only when nothing is in flight and the output slot
    // will be empty by the time its result lands
    assign pipe_empty = !tag1_reg.valid && !tag2_reg.valid;
    assign out_free   = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        i_next     = i_reg;
        k_next     = k_reg;
        j_next     = j_reg;
        done_next  = done_reg;
        tag0       = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    i_next     = '0;
                    k_next     = '0;
                    j_next     = '0;
                    done_next  = 1'b0;
                    state_next = ST_DRAIN;
                end
            end
            ST_ISSUE: begin
                tag0.valid     = 1'b1;
                tag0.first     = (j_reg == '0);
                tag0.last_term = (j_reg == dn_last);
                tag0.last_elem = (i_reg == dm_last) && (k_reg == dp_last);
                tag0.row       = i_reg;
                tag0.col       = k_reg;
                if (j_reg == dn_last) begin
                    j_next     = '0;
                    state_next = ST_DRAIN;
                    if (k_reg == dp_last) begin
                        k_next = '0;
                        if (i_reg == dm_last) begin
                            done_next = 1'b1;
                        end else begin
                            i_next = i_reg + IDX_W'(1);
                        end
                    end else begin
                        k_next = k_reg + IDX_W'(1);
                    end
                end else begin
                    j_next = j_reg + IDX_W'(1);
                end
            end
            ST_DRAIN: begin
                if (pipe_empty) begin
                    if (done_reg) begin
                        state_next = ST_IDLE;
                    end else if (out_free) begin
                        state_next = ST_ISSUE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b1;
            i_reg     <= '0;
            k_reg     <= '0;
            j_reg     <= '0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
            i_reg     <= i_next;
            k_reg     <= k_next;
            j_reg     <= j_next;
        end
    end

    // stage 1: RAM data valid, multiply; stage 2: accumulate
    assign prod_next = SUM_W'($signed(a_rdata)) * SUM_W'($signed(b_rdata));

    assign acc_base = tag2_reg.first ? '0 : acc_reg;
    assign acc_wide = {acc_base[SUM_W-1], acc_base} + {prod_reg[SUM_W-1], prod_reg};

    always_comb begin
        if (acc_wide[SUM_W] != acc_wide[SUM_W-1]) begin
            acc_next = acc_wide[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            acc_next = acc_wide[SUM_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag1_reg.valid <= 1'b0;
            tag2_reg.valid <= 1'b0;
        end else begin
            tag1_reg <= tag0;
            tag2_reg <= tag1_reg;
        end
        prod_reg <= prod_next;
        if (tag2_reg.valid) begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (tag2_reg.valid && tag2_reg.last_term) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (tag2_reg.valid && tag2_reg.last_term) begin
            out_row_reg  <= tag2_reg.row;
            out_col_reg  <= tag2_reg.col;
            out_sum_reg  <= acc_next;
            out_last_reg <= tag2_reg.last_elem;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_out_row = out_row_reg;
    assign m_out_col = out_col_reg;
    assign m_sum     = out_sum_reg;
    assign m_last    = out_last_reg;

    `DMM_ASSERT_NOW(a_land_into_empty, aclk, aresetn, tag2_reg.valid && tag2_reg.last_term, !m_valid_reg)
    `DMM_ASSERT_NOW(a_issue_slot_free, aclk, aresetn, state_reg == ST_ISSUE, !m_valid_reg)
    `DMM_ASSERT_NOW(a_idle_pipe_empty, aclk, aresetn, state_reg == ST_IDLE, pipe_empty)
endmodule

// File: bench/tb.sv
// Self-checking bench for dense_matrix_multiply: loads A/B elements, runs
// compute commands and checks every result element against a local predictor.
// Depends on dmm_pkg and the dense_matrix_multiply RTL.
`timescale 1ns / 100ps

module tb;
    import dmm_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_ITEMS  = 260;
    localparam int CYCLE_LIMIT   = 5_000_000;

    // mode 3 has no meaning; the block must drop it
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [SUM_W-1:0] sum;
        logic             last;
    } result_t;

    typedef enum logic {STEP_ITEM, STEP_CFG} step_kind_t;

    typedef struct {
        step_kind_t         kind;
        logic [MODE_W-1:0]  mode;
        logic [IDX_W-1:0]   row;
        logic [IDX_W-1:0]   col;
        logic [VALUE_W-1:0] value;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [DIM_W-1:0]   reg_val;
        bit                 typed;
        logic [SUM_W-1:0]   sum;
    } step_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0]     cfg_data  = '0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    logic [MODE_W-1:0]    s_mode    = '0;
    logic [IDX_W-1:0]     s_row     = '0;
    logic [IDX_W-1:0]     s_col     = '0;
    logic [VALUE_W-1:0]   s_value   = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    logic [IDX_W-1:0]     m_out_row;
    logic [IDX_W-1:0]     m_out_col;
    logic [SUM_W-1:0]     m_sum;
    logic                 m_last;

    dense_matrix_multiply u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_mode    (s_mode),
        .s_row     (s_row),
        .s_col     (s_col),
        .s_value   (s_value),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_out_row (m_out_row),
        .m_out_col (m_out_col),
        .m_sum     (m_sum),
        .m_last    (m_last)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // predictor state
    logic [VALUE_W-1:0] left_mat  [DEPTH];
    logic [VALUE_W-1:0] right_mat [DEPTH];
    bit                 a_loaded  [DEPTH];
    bit                 b_loaded  [DEPTH];
    logic [DIM_W-1:0]   dim_m = 4'd1;
    logic [DIM_W-1:0]   dim_n = 4'd1;
    logic [DIM_W-1:0]   dim_p = 4'd1;

    result_t pending_results[$];
    int      fail_count  = 0;
    int      cycle_count = 0;
    bit      quiet       = 1'b0;
    int      ready_left  = 0;
    int      stall_len;

    function automatic int eff_dim(logic [DIM_W-1:0] d);
        if (d == '0) return 1;
        if (d > DIM_W'(MAX_DIM)) return MAX_DIM;
        return int'(d);
    endfunction

    // Update the stores on a load, or queue every element of C on a compute.
    function automatic void apply_item(logic [MODE_W-1:0] mode, logic [IDX_W-1:0] row,
                                       logic [IDX_W-1:0] col, logic [VALUE_W-1:0] value);
        int dm, dn, dp, idx;
        logic signed [SUM_W-1:0] acc, prod, total;
        longint a, b;
        dm  = eff_dim(dim_m);
        dn  = eff_dim(dim_n);
        dp  = eff_dim(dim_p);
        idx = int'(row) * MAX_DIM + int'(col);
        case (mode)
            MODE_LOAD_A: begin
                if (row < dm && col < dn) begin
                    left_mat[idx] = value;
                    a_loaded[idx] = 1'b1;
                end
            end
            MODE_LOAD_B: begin
                if (row < dn && col < dp) begin
                    right_mat[idx] = value;
                    b_loaded[idx] = 1'b1;
                end
            end
            MODE_COMPUTE: begin
                for (int i = 0; i < dm; i++) begin
                    for (int k = 0; k < dp; k++) begin
                        acc = '0;
                        for (int j = 0; j < dn; j++) begin
                            a = int'(left_mat[i * MAX_DIM + j]);
                            b = int'(right_mat[j * MAX_DIM + k]);
                            prod  = a * b;
                            total = acc + prod;
                            // clamp when both terms share a sign and the sum flips it
                            if (!acc[SUM_W-1] && !prod[SUM_W-1] && total[SUM_W-1])
                                total = SUM_MAX;
                            else if (acc[SUM_W-1] && prod[SUM_W-1] && !total[SUM_W-1])
                                total = SUM_MIN;
                            acc = total;
                        end
                        pending_results.push_back(result_t'{IDX_W'(i), IDX_W'(k), acc,
                                                  (i == dm - 1 && k == dp - 1)});
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // Mostly zero, sometimes short, now and then a long pause.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return $urandom_range(10, 40);
        if (r < 6) return $urandom_range(1, 3);
        return 0;
    endfunction

    function automatic logic [VALUE_W-1:0] rand_value();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'(int'($urandom_range(0, 32'h3_FFFF)) - 32'h2_0000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        case ($urandom_range(0, 11))
            0: return '0;
            1: return DIM_W'($urandom_range(9, 15));
            2: return DIM_W'(MAX_DIM);
            3: return DIM_W'($urandom_range(5, 7));
            default: return DIM_W'($urandom_range(1, 4));
        endcase
    endfunction

    function automatic step_t item_step(logic [MODE_W-1:0] mode, logic [IDX_W-1:0] row,
                                       logic [IDX_W-1:0] col, logic [VALUE_W-1:0] value);
        return step_t'{STEP_ITEM, mode, row, col, value, CFG_ROWS_M, '0, 1'b0, '0};
    endfunction

    function automatic step_t compute_step(bit typed, logic [SUM_W-1:0] sum);
        return step_t'{STEP_ITEM, MODE_COMPUTE, '0, '0, '0, CFG_ROWS_M, '0, typed, sum};
    endfunction

    function automatic step_t cfg_step(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
        return step_t'{STEP_CFG, MODE_UNUSED, '0, '0, '0, idx, val, 1'b0, '0};
    endfunction

    // One input transfer; leaves s_valid high so the next item can follow directly.
    task automatic send_item(logic [MODE_W-1:0] mode, logic [IDX_W-1:0] row,
                             logic [IDX_W-1:0] col, logic [VALUE_W-1:0] value,
                             bit typed, logic [SUM_W-1:0] typed_sum);
        int gap;
        gap = quiet ? 0 : idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mode  <= mode;
        s_row   <= row;
        s_col   <= col;
        s_value <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (typed)
            pending_results.push_back(result_t'{'0, '0, typed_sum, 1'b1});
        else
            apply_item(mode, row, col, value);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_ROWS_M:  dim_m = val;
            CFG_INNER_N: dim_n = val;
            CFG_COLS_P:  dim_p = val;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic hold_until_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // Block idle: nothing outstanding and the pipeline has had time to empty.
    task automatic settle();
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Occasionally slip in an item the block must drop.
    task automatic add_noise(int dm, int dn, int dp);
        logic [MODE_W-1:0] mode;
        logic [IDX_W-1:0]  row, col;
        if ($urandom_range(0, 5) == 0) begin
            mode = $urandom_range(0, 1) ? MODE_LOAD_B : MODE_LOAD_A;
            row  = IDX_W'($urandom_range(0, 7));
            col  = IDX_W'($urandom_range(0, 7));
            if (mode == MODE_LOAD_A && row < dm && col < dn) mode = MODE_UNUSED;
            if (mode == MODE_LOAD_B && row < dn && col < dp) mode = MODE_UNUSED;
            send_item(mode, row, col, $urandom, 1'b0, '0);
        end
    endtask

    // Result side: ready with random stalls.
    always @(posedge aclk) begin
        if (ready_left != 0) begin
            ready_left <= ready_left - 1;
        end else begin
            stall_len = quiet ? 0 : idle_len();
            if (stall_len == 0) begin
                m_ready    <= 1'b1;
                ready_left <= $urandom_range(0, 5);
            end else begin
                m_ready    <= 1'b0;
                ready_left <= stall_len - 1;
            end
        end
    end

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: out_row %0d out_col %0d sum %h last %0b",
                       m_out_row, m_out_col, m_sum, m_last);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_out_row !== want.row) begin
                    $error("out_row: expected %0d, actual %0d", want.row, m_out_row);
                    fail_count++;
                end
                if (m_out_col !== want.col) begin
                    $error("out_col: expected %0d, actual %0d", want.col, m_out_col);
                    fail_count++;
                end
                if (m_sum !== want.sum) begin
                    $error("sum: expected %h, actual %h", want.sum, m_sum);
                    fail_count++;
                end
                if (m_last !== want.last) begin
                    $error("last: expected %0b, actual %0b", want.last, m_last);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    initial begin
        step_t script[$];
        int    dm, dn, dp, items_sent;
        bit    held;

        // Directed: reset dims (1x1x1), ignored loads, extremes, saturation both ways,
        // saturation followed by recovery, zero register values.
        script.push_back(item_step(MODE_LOAD_A, 3'd0, 3'd0, 32'h0001_0000));
        script.push_back(item_step(MODE_LOAD_B, 3'd0, 3'd0, 32'h0002_0000));
        script.push_back(compute_step(1'b1, 64'h0000_0002_0000_0000));
        script.push_back(item_step(MODE_LOAD_A, 3'd7, 3'd7, 32'hFFFF_FFFF));
        script.push_back(item_step(MODE_LOAD_B, 3'd0, 3'd7, 32'h7FFF_FFFF));
        script.push_back(item_step(MODE_UNUSED, 3'd7, 3'd7, 32'h8000_0000));
        script.push_back(compute_step(1'b1, 64'h0000_0002_0000_0000));
        script.push_back(item_step(MODE_LOAD_A, 3'd0, 3'd0, 32'h8000_0000));
        script.push_back(item_step(MODE_LOAD_B, 3'd0, 3'd0, 32'h8000_0000));
        script.push_back(compute_step(1'b1, 64'h4000_0000_0000_0000));
        script.push_back(cfg_step(CFG_INNER_N, 4'd2));
        script.push_back(item_step(MODE_LOAD_A, 3'd0, 3'd1, 32'h8000_0000));
        script.push_back(item_step(MODE_LOAD_B, 3'd1, 3'd0, 32'h8000_0000));
        script.push_back(compute_step(1'b1, 64'h7FFF_FFFF_FFFF_FFFF));
        script.push_back(cfg_step(CFG_INNER_N, 4'd3));
        script.push_back(item_step(MODE_LOAD_A, 3'd0, 3'd0, 32'h7FFF_FFFF));
        script.push_back(item_step(MODE_LOAD_A, 3'd0, 3'd1, 32'h7FFF_FFFF));
        script.push_back(item_step(MODE_LOAD_A, 3'd0, 3'd2, 32'h7FFF_FFFF));
        script.push_back(item_step(MODE_LOAD_B, 3'd2, 3'd0, 32'h8000_0000));
        script.push_back(compute_step(1'b1, 64'h8000_0000_0000_0000));
        // positive clamp, then a negative term pulls back from the limit
        script.push_back(item_step(MODE_LOAD_A, 3'd0, 3'd0, 32'h8000_0000));
        script.push_back(item_step(MODE_LOAD_A, 3'd0, 3'd1, 32'h8000_0000));
        script.push_back(compute_step(1'b0, '0));
        script.push_back(cfg_step(CFG_ROWS_M, 4'd0));
        script.push_back(cfg_step(CFG_COLS_P, 4'd0));
        script.push_back(cfg_step(CFG_INNER_N, 4'd1));
        script.push_back(compute_step(1'b1, 64'h4000_0000_0000_0000));
        script.push_back(item_step(MODE_LOAD_A, 3'd0, 3'd0, 32'h0000_0000));
        script.push_back(compute_step(1'b1, '0));

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (script[r]) begin
            if (script[r].kind == STEP_CFG) begin
                settle();
                write_reg(script[r].reg_idx, script[r].reg_val);
            end else begin
                send_item(script[r].mode, script[r].row, script[r].col, script[r].value,
                          script[r].typed, script[r].sum);
            end
        end

        // Random phases: new dims, fill whatever the product will read, then
        // reload a few entries and compute, a few times per phase.
        items_sent = 0;
        held = 1'b0;
        while (items_sent < RANDOM_ITEMS) begin
            settle();
            quiet = ($urandom_range(0, 3) == 0);
            write_reg(CFG_ROWS_M, pick_dim());
            write_reg(CFG_INNER_N, pick_dim());
            write_reg(CFG_COLS_P, pick_dim());
            dm = eff_dim(dim_m);
            dn = eff_dim(dim_n);
            dp = eff_dim(dim_p);
            repeat ($urandom_range(1, 3)) begin
                for (int i = 0; i < dm; i++) begin
                    for (int j = 0; j < dn; j++) begin
                        if (!a_loaded[i * MAX_DIM + j]) begin
                            add_noise(dm, dn, dp);
                            send_item(MODE_LOAD_A, IDX_W'(i), IDX_W'(j), rand_value(),
                                      1'b0, '0);
                            items_sent++;
                        end
                    end
                end
                for (int j = 0; j < dn; j++) begin
                    for (int k = 0; k < dp; k++) begin
                        if (!b_loaded[j * MAX_DIM + k]) begin
                            add_noise(dm, dn, dp);
                            send_item(MODE_LOAD_B, IDX_W'(j), IDX_W'(k), rand_value(),
                                      1'b0, '0);
                            items_sent++;
                        end
                    end
                end
                repeat ($urandom_range(0, 5)) begin
                    add_noise(dm, dn, dp);
                    if ($urandom_range(0, 1))
                        send_item(MODE_LOAD_A, IDX_W'($urandom_range(0, dm - 1)),
                                  IDX_W'($urandom_range(0, dn - 1)), rand_value(), 1'b0, '0);
                    else
                        send_item(MODE_LOAD_B, IDX_W'($urandom_range(0, dn - 1)),
                                  IDX_W'($urandom_range(0, dp - 1)), rand_value(), 1'b0, '0);
                    items_sent++;
                end
                add_noise(dm, dn, dp);
                send_item(MODE_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), $urandom,
                          1'b0, '0);
                items_sent++;
                if (!held || $urandom_range(0, 3) == 0) begin
                    hold_until_drained();
                    held = 1'b1;
                end
            end
        end

        settle();
        if (fail_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

// File: dense_matrix_multiply.f
+incdir+design
design/dmm_pkg.sv
design/dmm_ram.sv
design/dense_matrix_multiply.sv
bench/tb.sv
